/* rtl/core/mp2r_pkg.sv */
// ----------------------------------------------------------------------------
// mp2r_pkg
// Shared types, constants and helpers for the masked pixel to RGB888 converter.
// ----------------------------------------------------------------------------
package mp2r_pkg;

    // Width of a mask register and of the config data bus.
    localparam int DATA_W = 32;
    // Config address width: three registers at byte offsets 0, 4 and 8.
    localparam int ADDR_W = 4;
    // Width of the repeated-field window used by the scaler.
    localparam int ACC_W = 40;
    // Run length of a field, 0..32.
    localparam int LEN_W = 6;
    // Bit position inside a 32-bit word.
    localparam int POS_W = 5;
    // Register stages from input to output register.
    localparam int NUM_STAGES = 7;

    localparam logic [DATA_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [DATA_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [DATA_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

    typedef enum logic [1:0] {
        REG_RED_MASK   = 2'd0,
        REG_GREEN_MASK = 2'd1,
        REG_BLUE_MASK  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
    } t_mask_set;

    // Per-stage load enables, shared by every lane.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Index of the lowest set bit; 32 when the word is zero.
    function automatic logic [LEN_W-1:0] lsb_pos(input logic [DATA_W-1:0] x);
        logic [DATA_W:0]  y;
        logic [DATA_W:0]  oh;
        logic [LEN_W-1:0] p;
        y  = {1'b1, x};
        oh = y & (~y + (DATA_W+1)'(1));
        p  = '0;
        for (int i = 0; i <= DATA_W; i++) begin
            if (oh[i]) begin
                p = p | LEN_W'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/core/mp2r_cfg.sv */
// ----------------------------------------------------------------------------
// mp2r_cfg
// APB register file holding the red, green and blue field masks.
// ----------------------------------------------------------------------------
module mp2r_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mp2r_pkg::ADDR_W-1:0]  paddr,
    input  logic [mp2r_pkg::DATA_W-1:0]  pwdata,
    output logic [mp2r_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output mp2r_pkg::t_mask_set          o_masks
);

    mp2r_pkg::t_mask_set r_masks;
    mp2r_pkg::t_reg_idx  idx;
    logic                wr_en;

    assign idx    = mp2r_pkg::t_reg_idx'(paddr[mp2r_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks.red   <= mp2r_pkg::RED_MASK_RST;
            r_masks.green <= mp2r_pkg::GREEN_MASK_RST;
            r_masks.blue  <= mp2r_pkg::BLUE_MASK_RST;
        end else if (wr_en) begin
            case (idx)
                mp2r_pkg::REG_RED_MASK:   r_masks.red   <= pwdata;
                mp2r_pkg::REG_GREEN_MASK: r_masks.green <= pwdata;
                mp2r_pkg::REG_BLUE_MASK:  r_masks.blue  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            mp2r_pkg::REG_RED_MASK:   prdata = r_masks.red;
            mp2r_pkg::REG_GREEN_MASK: prdata = r_masks.green;
            mp2r_pkg::REG_BLUE_MASK:  prdata = r_masks.blue;
            default:                  prdata = '0;
        endcase
    end

    assign o_masks = r_masks;

endmodule

/* rtl/core/mp2r_ctrl.sv */
// ----------------------------------------------------------------------------
// mp2r_ctrl
// Valid bits and per-stage load enables of the conversion pipeline.
// ----------------------------------------------------------------------------
module mp2r_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mp2r_pkg::t_pipe_ctl   o_ctl
);

    localparam int N = mp2r_pkg::NUM_STAGES;

    logic [N-1:0] r_valid;
    logic [N-1:0] n_valid;
    logic [N-1:0] en;

    // A stage loads when it is empty or its successor loads too.
    always_comb begin
        en[N-1] = !r_valid[N-1] || i_ready;
        for (int k = N-2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < N; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_valid[N-1];
    assign o_ctl.en  = en;

endmodule

/* rtl/core/mp2r_lane.sv */
// ----------------------------------------------------------------------------
// mp2r_lane
// One color channel: extract the masked field and scale it to 8 bits.
// ----------------------------------------------------------------------------
module mp2r_lane #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                         i_clk,
    input  mp2r_pkg::t_pipe_ctl          i_ctl,
    input  logic [PIXEL_BITS-1:0]        i_word,
    input  logic [mp2r_pkg::DATA_W-1:0]  i_mask,
    output logic [7:0]                   o_value
);

    localparam int DW = mp2r_pkg::DATA_W;
    localparam int AW = mp2r_pkg::ACC_W;
    localparam int LW = mp2r_pkg::LEN_W;
    localparam int PW = mp2r_pkg::POS_W;

    // stage 1: find field position
    logic [PIXEL_BITS-1:0] r_word1;
    logic [DW-1:0]         r_mask1;
    logic [PW-1:0]         r_pos1;
    logic                  r_nz1;
    // stage 2: align field to bit 0
    logic [DW-1:0]         r_sw2;
    logic [DW-1:0]         r_sm2;
    logic                  r_nz2;
    // stage 3: run length and field value
    logic [LW-1:0]         r_len3;
    logic [DW-1:0]         r_val3;
    logic                  r_nz3;
    // stage 4: left-align field in the window
    logic [AW-1:0]         r_e4;
    logic [LW-1:0]         r_len4;
    logic                  r_nz4;
    // stage 5/6: repeat the field through the window
    logic [AW-1:0]         r_t5;
    logic [DW-1:0]         r_a5;
    logic [LW-1:0]         r_len5;
    logic                  r_nz5;
    logic [AW-1:0]         r_t6;
    logic [DW-1:0]         r_a6;
    logic [LW-1:0]         r_len6;
    logic                  r_nz6;
    // stage 7: output
    logic [7:0]            r_res7;

    logic [LW-1:0] n_pos1;
    logic [DW-1:0] n_run3;
    logic [AW-1:0] n_e4;
    logic [AW-1:0] n_t1;
    logic [AW-1:0] n_t2;
    logic [AW-1:0] n_t3;
    logic [AW-1:0] n_t4;
    logic [DW-1:0] n_win7;
    logic [DW-1:0] n_him7;
    logic [7:0]    n_top7;
    logic [7:0]    n_res7;

    assign n_pos1 = mp2r_pkg::lsb_pos(i_mask);
    assign n_run3 = r_sm2 & ~(r_sm2 + DW'(1));
    assign n_e4   = AW'(r_val3) << (LW'(AW) - r_len3);
    assign n_t1   = r_e4 | (r_e4 >> r_len4);
    assign n_t2   = n_t1 | (n_t1 >> {r_len4, 1'b0});
    assign n_t3   = r_t5 | (r_t5 >> {r_len5, 2'b00});
    assign n_t4   = n_t3 | (n_t3 >> {r_len5, 3'b000});

    // The field value over 2^len-1 repeats the field forever; the top byte
    // of that pattern, less one when the following window is below the
    // field itself, is the scaled result.
    assign n_him7 = ~DW'(0) << (LW'(DW) - r_len6);
    assign n_win7 = r_t6[DW-1:0] & n_him7;
    assign n_top7 = r_t6[AW-1:DW];

    always_comb begin
        if (!r_nz6) begin
            n_res7 = '0;
        end else if (n_win7 >= r_a6) begin
            n_res7 = n_top7;
        end else begin
            n_res7 = n_top7 - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_word1 <= i_word;
            r_mask1 <= i_mask;
            r_pos1  <= n_pos1[PW-1:0];
            r_nz1   <= |i_mask;
        end
        if (i_ctl.en[1]) begin
            r_sw2 <= DW'(r_word1) >> r_pos1;
            r_sm2 <= r_mask1 >> r_pos1;
            r_nz2 <= r_nz1;
        end
        if (i_ctl.en[2]) begin
            r_len3 <= mp2r_pkg::lsb_pos(~r_sm2);
            r_val3 <= r_sw2 & n_run3;
            r_nz3  <= r_nz2;
        end
        if (i_ctl.en[3]) begin
            r_e4   <= n_e4;
            r_len4 <= r_len3;
            r_nz4  <= r_nz3;
        end
        if (i_ctl.en[4]) begin
            r_t5   <= n_t2;
            r_a5   <= r_e4[AW-1:AW-DW];
            r_len5 <= r_len4;
            r_nz5  <= r_nz4;
        end
        if (i_ctl.en[5]) begin
            r_t6   <= n_t4;
            r_a6   <= r_a5;
            r_len6 <= r_len5;
            r_nz6  <= r_nz5;
        end
        if (i_ctl.en[6]) begin
            r_res7 <= n_res7;
        end
    end

    assign o_value = r_res7;

endmodule

/* rtl/core/mask_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// mask_pixel_to_rgb888
// Convert a packed pixel word to 8-bit red, green and blue using per-channel
// field masks.
// ----------------------------------------------------------------------------
//  port group   | direction | handshake              | payload
//  -------------+-----------+------------------------+------------------------
//  pixel in     | in        | i_valid / o_ready      | i_pixel[31:0]
//  color out    | out       | o_valid / i_ready      | o_red, o_green, o_blue
//  config       | in/out    | APB, pready tied high  | paddr, pwdata, prdata
//
//  Throughput: one pixel per clock while the output is not stalled; o_valid rises
//  once a pixel has passed the seven register stages of each channel lane.
//  Reset (synchronous, i_rst_n low) empties the pipeline and loads the masks
//  with the RGB888 layout 0x00FF0000 / 0x0000FF00 / 0x000000FF.
//  A stall at the output holds only the stages that are full; empty stages
//  keep filling, so nothing is dropped or repeated.
//  Write masks only while no request is in flight.
// ----------------------------------------------------------------------------
module mask_pixel_to_rgb888 #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel request
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [31:0]                  i_pixel,
    // color result
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mp2r_pkg::ADDR_W-1:0]  paddr,
    input  logic [mp2r_pkg::DATA_W-1:0]  pwdata,
    output logic [mp2r_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    mp2r_pkg::t_mask_set  masks;
    mp2r_pkg::t_pipe_ctl  ctl;
    logic [PIXEL_BITS-1:0] word;

    // Drop pixel bits above the configured word width.
    assign word = i_pixel[PIXEL_BITS-1:0];

    // Mask registers; the user must keep them static while requests are in flight
    // (the block does not enforce it); the lanes read them directly at the input stage.
    mp2r_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_masks (masks)
    );

    // Advance valid bits and generate per-stage load enables.
    mp2r_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (ctl)
    );

    // One datapath lane per color; all three move in lock step.
    mp2r_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane_red (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_word  (word),
        .i_mask  (masks.red),
        .o_value (o_red)
    );

    mp2r_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane_green (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_word  (word),
        .i_mask  (masks.green),
        .o_value (o_green)
    );

    mp2r_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane_blue (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_word  (word),
        .i_mask  (masks.blue),
        .o_value (o_blue)
    );

endmodule

/* rtl/core/mp2r_chk.sv */
// ----------------------------------------------------------------------------
// mp2r_chk
// Port-level checks for the masked pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
module mp2r_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    // An empty output register frees the whole pipeline.
    a_empty_out_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("output empty but input not ready");

    // A taken result lets every stage advance.
    a_ready_chain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("downstream ready did not reach the input");

    // Reset flushes every result.
    a_reset_flush : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // Hold a stalled result.
    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_red, o_green, o_blue}))
        else $error("stalled result changed or vanished");

    // Never insert wait states on the config port.
    a_no_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("config access stalled");

endmodule

bind mask_pixel_to_rgb888 mp2r_chk u_mp2r_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue),
    .psel    (psel),
    .penable (penable),
    .pready  (pready)
);
